// ----- sv/rvfp_pkg.sv -----
// Shared types and constants for the radar vitals frame parser.
`default_nettype none
package rvfp_pkg;

   localparam logic [7:0]  START_BYTE    = 8'h01;
   localparam logic [15:0] KIND_BREATH   = 16'h0A14;
   localparam logic [15:0] KIND_HEART    = 16'h0A15;
   localparam logic [15:0] KIND_DIST     = 16'h0A16;
   localparam logic [15:0] KIND_PRESENCE = 16'h0F09;
   localparam logic [31:0] NEG_ZERO      = 32'h8000_0000;

   localparam logic [15:0] MAX_LEN_RESET    = 16'd30;
   localparam logic [30:0] BREATH_MAX_RESET = 31'h4270_0000;
   localparam logic [30:0] HEART_MAX_RESET  = 31'h437A_0000;

   // configuration register indexes
   localparam logic [1:0] CSR_MAX_LEN    = 2'd0;
   localparam logic [1:0] CSR_BREATH_MAX = 2'd1;
   localparam logic [1:0] CSR_HEART_MAX  = 2'd2;

   typedef enum logic [3:0] {
      PH_HUNT   = 4'b0001,
      PH_HEADER = 4'b0010,
      PH_DATA   = 4'b0100,
      PH_CHECK  = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_HDR_BAD  = 2'd1,
      ST_TOO_LONG = 2'd2,
      ST_DATA_BAD = 2'd3
   } status_type;

   // end-of-frame event from the parser
   typedef struct packed {
      logic        fire;
      status_type  status;
      logic [15:0] kind;
      logic [15:0] length;
      logic [63:0] head;   // payload byte 0 in the low bits
   } frame_done_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] hdr_type;
      logic [31:0] breathing_bits;
      logic [31:0] heart_bits;
      logic [31:0] distance_bits;
      logic        present;
      logic [31:0] frame_total;
      logic [31:0] error_total;
   } rsp_type;

endpackage
`default_nettype wire

// ----- sv/rvfp_parser.sv -----
// Byte-level frame parser: start hunt, header checksum, payload XOR and head capture.
`default_nettype none
module rvfp_parser (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_accept,
   input  wire logic [7:0]             rx_byte,
   input  wire logic [15:0]            max_payload_len,
   output rvfp_pkg::frame_done_type    done
);
   import rvfp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  hcnt_ff, hcnt_in;
   logic [7:0]  hxor_ff, hxor_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] kind_ff, kind_in;
   logic [15:0] pcnt_ff, pcnt_in;
   logic [7:0]  pxor_ff, pxor_in;
   logic [7:0]  head_ff [8];
   logic [15:0] pcnt_inc;

   assign pcnt_inc = pcnt_ff + 16'd1;

   always_comb begin
      phase_in = phase_ff;
      hcnt_in  = hcnt_ff;
      hxor_in  = hxor_ff;
      len_in   = len_ff;
      kind_in  = kind_ff;
      pcnt_in  = pcnt_ff;
      pxor_in  = pxor_ff;
      done        = '0;
      done.kind   = kind_ff;
      done.length = len_ff;
      for (int i = 0; i < 8; i++) begin
         done.head[i*8 +: 8] = head_ff[i];
      end
      if (req_accept) begin
         case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == START_BYTE) begin
                  hxor_in  = START_BYTE;
                  hcnt_in  = 3'd1;
                  phase_in = PH_HEADER;
               end
            end
            PH_HEADER: begin
               if (hcnt_ff != 3'd7) begin
                  case (hcnt_ff)
                     3'd3:    len_in  = {rx_byte, 8'h00};
                     3'd4:    len_in  = {len_ff[15:8], rx_byte};
                     3'd5:    kind_in = {rx_byte, 8'h00};
                     3'd6:    kind_in = {kind_ff[15:8], rx_byte};
                     default: ;
                  endcase
                  hxor_in = hxor_ff ^ rx_byte;
                  hcnt_in = hcnt_ff + 3'd1;
               end else begin
                  hcnt_in  = 3'd0;
                  phase_in = PH_HUNT;
                  if (~hxor_ff != rx_byte) begin
                     done.fire   = 1'b1;
                     done.status = ST_HDR_BAD;
                     done.kind   = 16'h0000;
                  end else begin
                     pcnt_in = 16'd0;
                     pxor_in = 8'h00;
                     if (len_ff > max_payload_len) begin
                        done.fire   = 1'b1;
                        done.status = ST_TOO_LONG;
                     end else begin
                        phase_in = (len_ff == 16'd0) ? PH_CHECK : PH_DATA;
                     end
                  end
               end
            end
            PH_DATA: begin
               pxor_in = pxor_ff ^ rx_byte;
               pcnt_in = pcnt_inc;
               if (pcnt_inc >= len_ff) phase_in = PH_CHECK;
            end
            PH_CHECK: begin
               phase_in  = PH_HUNT;
               done.fire = 1'b1;
               // an empty payload skips the data checksum
               done.status = (len_ff == 16'd0 || ~pxor_ff == rx_byte) ? ST_OK : ST_DATA_BAD;
            end
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         hcnt_ff  <= 3'd0;
         hxor_ff  <= 8'h00;
         len_ff   <= 16'd0;
         kind_ff  <= 16'd0;
         pcnt_ff  <= 16'd0;
         pxor_ff  <= 8'h00;
      end else begin
         phase_ff <= phase_in;
         hcnt_ff  <= hcnt_in;
         hxor_ff  <= hxor_in;
         len_ff   <= len_in;
         kind_ff  <= kind_in;
         pcnt_ff  <= pcnt_in;
         pxor_ff  <= pxor_in;
      end
   end

   // only the first eight payload bytes are kept
   always_ff @(posedge clock) begin
      if (req_accept && phase_ff == PH_DATA && pcnt_ff < 16'd8) begin
         head_ff[pcnt_ff[2:0]] <= rx_byte;
      end
   end

   a_check_to_hunt: assert property (@(posedge clock) disable iff (reset)
      req_accept && phase_ff == PH_CHECK |=> phase_ff == PH_HUNT)
      else $error("parser did not return to hunt after checksum byte");
   a_header_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HEADER |-> hcnt_ff != 3'd0)
      else $error("header phase with zero byte count");
   a_data_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> pcnt_ff < len_ff)
      else $error("payload count ran past frame length");

endmodule
`default_nettype wire

// ----- sv/rvfp_vitals.sv -----
// Vital value registers, range checks and frame counters; builds the result.
`default_nettype none
module rvfp_vitals (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire rvfp_pkg::frame_done_type done,
   input  wire logic [30:0]             breathing_max_bits,
   input  wire logic [30:0]             heart_max_bits,
   output rvfp_pkg::rsp_type            result
);
   import rvfp_pkg::*;

   logic [31:0] breath_ff, breath_in;
   logic [31:0] heart_ff, heart_in;
   logic [31:0] dist_ff, dist_in;
   logic        pres_ff, pres_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] rej_ff, rej_in;
   logic [31:0] word_lo, word_hi;
   logic        take;

   // -0.0 passes, other negatives fail, else integer compare against limit
   function automatic logic rate_ok(input logic [31:0] bits, input logic [30:0] limit);
      logic ok;
      if (bits == NEG_ZERO) ok = 1'b1;
      else if (bits[31]) ok = 1'b0;
      else ok = (bits[30:0] <= limit);
      return ok;
   endfunction

   assign word_lo = done.head[31:0];
   assign word_hi = done.head[63:32];
   assign take    = done.fire && done.status == ST_OK;

   always_comb begin
      breath_in = breath_ff;
      heart_in  = heart_ff;
      dist_in   = dist_ff;
      pres_in   = pres_ff;
      acc_in    = acc_ff;
      rej_in    = rej_ff;
      if (done.fire && !take) rej_in = rej_ff + 32'd1;
      if (take) begin
         acc_in = acc_ff + 32'd1;
         case (done.kind)
            KIND_BREATH: begin
               if (done.length >= 16'd4 && rate_ok(word_lo, breathing_max_bits))
                  breath_in = word_lo;
            end
            KIND_HEART: begin
               if (done.length >= 16'd4 && rate_ok(word_lo, heart_max_bits))
                  heart_in = word_lo;
            end
            KIND_DIST: begin
               if (done.length >= 16'd8 && word_lo != 32'd0) dist_in = word_hi;
            end
            KIND_PRESENCE: begin
               if (done.length >= 16'd1) pres_in = (done.head[7:0] != 8'h00);
            end
            default: ;
         endcase
      end
      result.status         = done.status;
      result.hdr_type       = done.kind;
      result.breathing_bits = breath_in;
      result.heart_bits     = heart_in;
      result.distance_bits  = dist_in;
      result.present        = pres_in;
      result.frame_total    = acc_in;
      result.error_total    = rej_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         breath_ff <= 32'd0;
         heart_ff  <= 32'd0;
         dist_ff   <= 32'd0;
         pres_ff   <= 1'b0;
         acc_ff    <= 32'd0;
         rej_ff    <= 32'd0;
      end else begin
         breath_ff <= breath_in;
         heart_ff  <= heart_in;
         dist_ff   <= dist_in;
         pres_ff   <= pres_in;
         acc_ff    <= acc_in;
         rej_ff    <= rej_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/rvfp_out_buf.sv -----
// Result register with one skid entry so requests keep flowing under backpressure.
`default_nettype none
module rvfp_out_buf (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire rvfp_pkg::rsp_type push_data,
   output logic                   push_ready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output rvfp_pkg::rsp_type      rsp_data
);
   import rvfp_pkg::*;

   logic    main_v_ff, main_v_in;
   logic    skid_v_ff, skid_v_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;

   always_comb begin
      main_v_in = main_v_ff;
      skid_v_in = skid_v_ff;
      main_in   = main_ff;
      skid_in   = skid_ff;
      if (!main_v_ff || rsp_tready) begin
         if (skid_v_ff) begin
            main_in   = skid_ff;
            main_v_in = 1'b1;
            skid_v_in = 1'b0;
         end else if (push) begin
            main_in   = push_data;
            main_v_in = 1'b1;
         end else begin
            main_v_in = 1'b0;
         end
      end else if (push) begin
         skid_in   = push_data;
         skid_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign push_ready = !skid_v_ff;
   assign rsp_tvalid = main_v_ff;
   assign rsp_data   = main_ff;

   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> main_v_ff)
      else $error("skid entry held while result register empty");
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> !push)
      else $error("result pushed into full buffer");
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff && rsp_tready |=> !skid_v_ff)
      else $error("skid entry not moved after result taken");

endmodule
`default_nettype wire

// ----- sv/radar_vitals_frame_parser_top.sv -----
// Radar vitals frame parser: one received byte per request, one result per frame.
// Latency: a result shows on rsp the cycle after its closing byte is accepted,
// later only while it waits behind an unread result.
// Throughput: one byte per cycle; req_tready drops only while the skid entry is full.
// Reset (synchronous, active high): parser hunts for the start byte, values and counters
// clear, configuration returns to max length 30 and limits 60.0 and 250.0.
`default_nettype none
module radar_vitals_frame_parser_top (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,    // rx_byte[7:0]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // hdr_type[15:0], breathing_bits[47:16], heart_bits[79:48], distance_bits[111:80],
   // present[112], frame_total[144:113], error_total[176:145], zero fill[183:177]
   output logic [183:0]      rsp_tdata,
   output logic [1:0]        rsp_tuser,    // status[1:0]
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_data
);
   import rvfp_pkg::*;

   logic [15:0]    max_len_ff;
   logic [30:0]    breath_max_ff;
   logic [30:0]    heart_max_ff;
   logic           req_accept;
   logic           buf_ready;
   frame_done_type done;
   rsp_type        result;
   rsp_type        rsp;

   assign csr_ready  = 1'b1;
   assign req_tready = buf_ready;
   assign req_accept = req_tvalid && buf_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff    <= MAX_LEN_RESET;
         breath_max_ff <= BREATH_MAX_RESET;
         heart_max_ff  <= HEART_MAX_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MAX_LEN:    max_len_ff    <= csr_data[15:0];
            CSR_BREATH_MAX: breath_max_ff <= csr_data[30:0];
            CSR_HEART_MAX:  heart_max_ff  <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   rvfp_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .req_accept      (req_accept),
      .rx_byte         (req_tdata),
      .max_payload_len (max_len_ff),
      .done            (done)
   );

   rvfp_vitals u_vitals (
      .clock              (clock),
      .reset              (reset),
      .done               (done),
      .breathing_max_bits (breath_max_ff),
      .heart_max_bits     (heart_max_ff),
      .result             (result)
   );

   rvfp_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (done.fire),
      .push_data  (result),
      .push_ready (buf_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp)
   );

   assign rsp_tdata = {7'b0, rsp.error_total, rsp.frame_total, rsp.present,
                       rsp.distance_bits, rsp.heart_bits, rsp.breathing_bits,
                       rsp.hdr_type};
   assign rsp_tuser = rsp.status;

endmodule
`default_nettype wire

// ----- dv/rvfp_frame_checker.sv -----
`timescale 1ns / 1ps
// Frame checker: tracks the parser state from the byte stream and checks each frame result.
module rvfp_frame_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [7:0]   req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [183:0] rsp_tdata,
   input  wire logic [1:0]   rsp_tuser,
   input  wire logic         csr_valid,
   input  wire logic         csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_data,
   output int                mismatches,
   output int                reports_due
);
   import rvfp_pkg::*;

   int fail_tally = 0;
   int due_count = 0;

   assign mismatches  = fail_tally;
   assign reports_due = due_count;

   logic [15:0] len_limit;
   logic [30:0] breath_limit;
   logic [30:0] heart_limit;

   phase_type   phase;
   logic [2:0]  hdr_count;
   logic [7:0]  hdr_sum;
   logic [15:0] frame_len;
   logic [15:0] frame_kind;
   logic [15:0] body_count;
   logic [7:0]  body_sum;
   logic [7:0]  body_head [8];

   logic [31:0] breath_now;
   logic [31:0] heart_now;
   logic [31:0] dist_now;
   logic        present_now;
   logic [31:0] good_frames;
   logic [31:0] bad_frames;

   rsp_type pending_reports[$];

   // -0.0 passes, any other negative fails, else compare as unsigned integers
   function automatic bit rate_in_range(input logic [31:0] bits, input logic [30:0] limit);
      if (bits == NEG_ZERO) return 1'b1;
      if (bits[31]) return 1'b0;
      return bits[30:0] <= limit;
   endfunction

   function automatic logic [31:0] head_word(input int at);
      return {body_head[at+3], body_head[at+2], body_head[at+1], body_head[at]};
   endfunction

   task automatic post_report(input status_type st, input logic [15:0] kind);
      rsp_type r;
      r.status         = st;
      r.hdr_type       = kind;
      r.breathing_bits = breath_now;
      r.heart_bits     = heart_now;
      r.distance_bits  = dist_now;
      r.present        = present_now;
      r.frame_total    = good_frames;
      r.error_total    = bad_frames;
      pending_reports.push_back(r);
   endtask

   task automatic apply_frame();
      good_frames++;
      case (frame_kind)
         KIND_BREATH: begin
            if (frame_len >= 4 && rate_in_range(head_word(0), breath_limit))
               breath_now = head_word(0);
         end
         KIND_HEART: begin
            if (frame_len >= 4 && rate_in_range(head_word(0), heart_limit))
               heart_now = head_word(0);
         end
         KIND_DIST: begin
            // range flag in bytes 0..3 gates the distance word
            if (frame_len >= 8 && head_word(0) != 32'h0)
               dist_now = head_word(4);
         end
         KIND_PRESENCE: begin
            if (frame_len >= 1)
               present_now = (body_head[0] != 8'h00);
         end
         default: ;
      endcase
   endtask

   task automatic parse_rx_byte(input logic [7:0] b);
      case (phase)
         PH_HUNT: begin
            if (b == START_BYTE) begin
               hdr_sum   = b;
               hdr_count = 3'd1;
               phase     = PH_HEADER;
            end
         end
         PH_HEADER: begin
            if (hdr_count < 3'd7) begin
               case (hdr_count)
                  3'd3: frame_len  = {b, 8'h00};
                  3'd4: frame_len[7:0] = b;
                  3'd5: frame_kind = {b, 8'h00};
                  3'd6: frame_kind[7:0] = b;
                  default: ;
               endcase
               hdr_sum   = hdr_sum ^ b;
               hdr_count = hdr_count + 3'd1;
            end else begin
               hdr_count = 3'd0;
               phase     = PH_HUNT;
               if (~hdr_sum != b) begin
                  bad_frames++;
                  post_report(ST_HDR_BAD, 16'h0000);
               end else begin
                  body_count = 16'd0;
                  body_sum   = 8'h00;
                  if (frame_len > len_limit) begin
                     bad_frames++;
                     post_report(ST_TOO_LONG, frame_kind);
                  end else begin
                     phase = (frame_len == 16'd0) ? PH_CHECK : PH_DATA;
                  end
               end
            end
         end
         PH_DATA: begin
            if (body_count < 16'd8) body_head[body_count[2:0]] = b;
            body_sum   = body_sum ^ b;
            body_count = body_count + 16'd1;
            if (body_count >= frame_len) phase = PH_CHECK;
         end
         default: begin
            // empty payload: closing byte is not compared
            phase = PH_HUNT;
            if (frame_len == 16'd0 || ~body_sum == b) begin
               apply_frame();
               post_report(ST_OK, frame_kind);
            end else begin
               bad_frames++;
               post_report(ST_DATA_BAD, frame_kind);
            end
         end
      endcase
   endtask

   task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         fail_tally++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      end
   endtask

   task automatic check_report();
      rsp_type want;
      if (pending_reports.size() == 0) begin
         fail_tally++;
         $display("%0t: result with none expected, status %0d hdr_type %h",
                  $time, rsp_tuser, rsp_tdata[15:0]);
      end else begin
         want = pending_reports.pop_front();
         check_field("status", {30'd0, want.status}, {30'd0, rsp_tuser});
         check_field("hdr_type", {16'd0, want.hdr_type}, {16'd0, rsp_tdata[15:0]});
         check_field("breathing_bits", want.breathing_bits, rsp_tdata[47:16]);
         check_field("heart_bits", want.heart_bits, rsp_tdata[79:48]);
         check_field("distance_bits", want.distance_bits, rsp_tdata[111:80]);
         check_field("present", {31'd0, want.present}, {31'd0, rsp_tdata[112]});
         check_field("frame_total", want.frame_total, rsp_tdata[144:113]);
         check_field("error_total", want.error_total, rsp_tdata[176:145]);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         len_limit    = MAX_LEN_RESET;
         breath_limit = BREATH_MAX_RESET;
         heart_limit  = HEART_MAX_RESET;
         phase        = PH_HUNT;
         hdr_count    = 3'd0;
         hdr_sum      = 8'h00;
         frame_len    = 16'd0;
         frame_kind   = 16'd0;
         body_count   = 16'd0;
         body_sum     = 8'h00;
         breath_now   = 32'h0;
         heart_now    = 32'h0;
         dist_now     = 32'h0;
         present_now  = 1'b0;
         good_frames  = 32'h0;
         bad_frames   = 32'h0;
         pending_reports.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_LEN:    len_limit    = csr_data[15:0];
               CSR_BREATH_MAX: breath_limit = csr_data[30:0];
               CSR_HEART_MAX:  heart_limit  = csr_data[30:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) parse_rx_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) check_report();
      end
      due_count = pending_reports.size();
   end

endmodule

// ----- dv/radar_vitals_frame_parser_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench top: drives byte frames and register writes into the parser and gives the verdict.
module radar_vitals_frame_parser_top_tb;
   import rvfp_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int PHASE_BYTES  = 175;
   localparam int PHASE_COUNT  = 6;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [183:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [31:0]  csr_data;

   int fail_count;
   int reports_due;
   int cycle_count = 0;
   int bytes_sent  = 0;
   bit sender_calm = 1'b0;

   int          cur_len_limit;
   logic [30:0] cur_breath_limit;
   logic [30:0] cur_heart_limit;
   logic [7:0]  frame_body[$];

   radar_vitals_frame_parser_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   rvfp_frame_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (fail_count),
      .reports_due (reports_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("radar_vitals_frame_parser_top verification failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      if (sender_calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // returns right after the accepting edge so valid can stay high into the next request
   task automatic send_rx_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if ($urandom_range(0, 149) == 0) sender_calm = !sender_calm;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MAX_LEN:    cur_len_limit    = int'(val[15:0]);
         CSR_BREATH_MAX: cur_breath_limit = val[30:0];
         CSR_HEART_MAX:  cur_heart_limit  = val[30:0];
         default: ;
      endcase
   endtask

   // wait for all results, then wait on for anything still in the pipe
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (reports_due != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   // rate words weighted toward the range check edges
   function automatic logic [31:0] rate_word(input logic [30:0] limit);
      case ($urandom_range(0, 8))
         0: return NEG_ZERO;
         1: return {1'b1, 31'($urandom_range(1, 32'h7FFF_FFFF))};
         2: return 32'h7FC0_0000;
         3: return {1'b0, limit};
         4: return {1'b0, limit} + 32'd1;
         5: return 32'h0;
         6: return $urandom();
         default: return 32'($urandom_range(0, {1'b0, limit}));
      endcase
   endfunction

   task automatic fill_body(input logic [15:0] kind, input int len);
      logic [31:0] w;
      frame_body.delete();
      repeat (len) frame_body.push_back(8'($urandom()));
      if (kind == KIND_BREATH) w = rate_word(cur_breath_limit);
      else if (kind == KIND_HEART) w = rate_word(cur_heart_limit);
      else w = ($urandom_range(0, 2) == 0) ? 32'h0 : $urandom();
      for (int i = 0; i < 4 && i < len; i++) frame_body[i] = w[8*i +: 8];
      if (kind == KIND_PRESENCE && len > 0 && $urandom_range(0, 1) == 1) frame_body[0] = 8'h00;
   endtask

   task automatic send_frame(input logic [15:0] kind, input logic [15:0] len,
                             input bit hdr_bad, input bit data_bad, input bit cut_short);
      logic [7:0] hdr [8];
      logic [7:0] sum;
      hdr[0] = START_BYTE;
      hdr[1] = 8'($urandom());
      hdr[2] = 8'($urandom());
      hdr[3] = len[15:8];
      hdr[4] = len[7:0];
      hdr[5] = kind[15:8];
      hdr[6] = kind[7:0];
      sum = 8'h00;
      for (int i = 0; i < 7; i++) sum = sum ^ hdr[i];
      hdr[7] = ~sum;
      if (hdr_bad) hdr[7] = hdr[7] ^ 8'($urandom_range(1, 255));
      foreach (hdr[i]) send_rx_byte(hdr[i]);
      if (hdr_bad || len > cur_len_limit) return;
      fill_body(kind, int'(len));
      sum = 8'h00;
      foreach (frame_body[i]) begin
         if (cut_short && i >= len / 2) return;
         send_rx_byte(frame_body[i]);
         sum = sum ^ frame_body[i];
      end
      if (cut_short) return;
      if (len == 16'd0) send_rx_byte(8'($urandom()));
      else if (data_bad) send_rx_byte(~sum ^ 8'($urandom_range(1, 255)));
      else send_rx_byte(~sum);
   endtask

   task automatic load_limits(input int p);
      case (p)
         1: begin
            write_csr(CSR_MAX_LEN, 32'd0);
            write_csr(CSR_BREATH_MAX, 32'h0);
            write_csr(CSR_HEART_MAX, 32'h0);
         end
         2: begin
            write_csr(CSR_MAX_LEN, 32'd65535);
            write_csr(CSR_BREATH_MAX, 32'h7F80_0000);
            write_csr(CSR_HEART_MAX, 32'h7F80_0000);
         end
         3: begin
            write_csr(CSR_MAX_LEN, 32'd12);
            write_csr(CSR_BREATH_MAX, 32'h3F80_0000);
            write_csr(CSR_HEART_MAX, 32'h4120_0000);
         end
         4: begin
            write_csr(CSR_MAX_LEN, $urandom_range(8, 40));
            write_csr(CSR_BREATH_MAX, $urandom_range(0, 32'h7F80_0000));
            write_csr(CSR_HEART_MAX, $urandom_range(0, 32'h7F80_0000));
         end
         default: begin
            write_csr(CSR_MAX_LEN, {16'd0, MAX_LEN_RESET});
            write_csr(CSR_BREATH_MAX, {1'b0, BREATH_MAX_RESET});
            write_csr(CSR_HEART_MAX, {1'b0, HEART_MAX_RESET});
         end
      endcase
   endtask

   // result side back-pressure
   initial begin
      int hold;
      int r;
      bit calm;
      hold = 0;
      calm = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 299) == 0) calm = !calm;
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (calm) begin
            rsp_tready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_tready <= 1'b1;
            end else if (r < 90) begin
               hold = $urandom_range(0, 2);
               rsp_tready <= 1'b0;
            end else begin
               hold = $urandom_range(9, 39);
               rsp_tready <= 1'b0;
            end
         end
      end
   end

   initial begin
      int r;
      int len;
      int min_len;
      logic [15:0] kind;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      csr_valid  = 1'b0;
      csr_index  = CSR_MAX_LEN;
      csr_data   = 32'h0;
      cur_len_limit    = int'(MAX_LEN_RESET);
      cur_breath_limit = BREATH_MAX_RESET;
      cur_heart_limit  = HEART_MAX_RESET;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // noise while hunting, empty payload, bad header, over-long length
      send_rx_byte(8'h00);
      send_rx_byte(8'hFF);
      send_frame(KIND_PRESENCE, 16'd0, 1'b0, 1'b0, 1'b0);
      send_frame(KIND_HEART, 16'd4, 1'b1, 1'b0, 1'b0);
      send_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p > 0) begin
            drain();
            load_limits(p);
         end
         bytes_sent = 0;
         while (bytes_sent < PHASE_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
               repeat ($urandom_range(1, 4)) send_rx_byte(8'($urandom()));
            end else begin
               case ($urandom_range(0, 9))
                  0, 1: kind = KIND_BREATH;
                  2, 3: kind = KIND_HEART;
                  4, 5: kind = KIND_DIST;
                  6, 7: kind = KIND_PRESENCE;
                  8: kind = 16'($urandom());
                  default: kind = ($urandom_range(0, 1) == 1) ? KIND_DIST + 16'd1
                                                               : KIND_PRESENCE - 16'd1;
               endcase
               case (kind)
                  KIND_BREATH, KIND_HEART: min_len = 4;
                  KIND_DIST: min_len = 8;
                  KIND_PRESENCE: min_len = 1;
                  default: min_len = 0;
               endcase
               len = $urandom_range(0, 99);
               if (len < 8 && cur_len_limit < 65535) begin
                  len = $urandom_range(cur_len_limit + 1, 65535);
               end else begin
                  if (len < 16) len = 0;
                  else if (len < 24) len = $urandom_range(1, 3);
                  else if (len < 28) len = $urandom_range(9, 300);
                  else len = min_len + $urandom_range(0, 4);
                  if (len > cur_len_limit) len = cur_len_limit;
               end
               send_frame(kind, 16'(len), $urandom_range(0, 99) < 8,
                          $urandom_range(0, 99) < 10, r < 11);
            end
         end
      end

      drain();
      repeat (20) @(negedge clock);
      if (fail_count == 0)
         $display("radar_vitals_frame_parser_top verification clean");
      else
         $display("radar_vitals_frame_parser_top verification failed");
      $finish;
   end

endmodule
